// ===== rtl/chtd_pkg.sv =====
`timescale 1ns / 1ps

package chtd_pkg;

   localparam int SIZE_BITS_DEFAULT = 31;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;

   localparam logic [1:0] TRAIL_LEN = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_payload;
      logic       finished;
      logic       malformed;
   } result_type;

endpackage

// ===== rtl/chtd_core.sv =====
`timescale 1ns / 1ps

module chtd_core #(
   parameter int SIZE_BITS = chtd_pkg::SIZE_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  logic [7:0]             byte_in,
   output chtd_pkg::result_type   result
);

   typedef enum logic [2:0] {
      PH_LEAD   = 3'd0,
      PH_DIGITS = 3'd1,
      PH_EXT    = 3'd2,
      PH_DATA   = 3'd3,
      PH_TRAIL  = 3'd4,
      PH_DONE   = 3'd5,
      PH_ERROR  = 3'd6
   } phase_type;

   phase_type            phase_ff, phase_in;
   logic [SIZE_BITS-1:0] size_accum_ff, size_accum_in;
   logic [SIZE_BITS-1:0] bytes_left_ff, bytes_left_in;
   logic                 got_digit_ff, got_digit_in;
   logic                 last_was_cr_ff, last_was_cr_in;
   logic [1:0]           skip_left_ff, skip_left_in;

   logic                 is_hex;
   logic [3:0]           hex_val;
   logic                 is_blank;
   logic                 line_end;
   logic                 size_full;

   always_comb begin
      is_hex  = 1'b1;
      hex_val = 4'd0;
      if (byte_in >= 8'h30 && byte_in <= 8'h39) begin
         hex_val = 4'(byte_in - 8'h30);
      end else if (byte_in >= 8'h61 && byte_in <= 8'h66) begin
         hex_val = 4'(byte_in - 8'h57);
      end else if (byte_in >= 8'h41 && byte_in <= 8'h46) begin
         hex_val = 4'(byte_in - 8'h37);
      end else begin
         is_hex = 1'b0;
      end
   end

   assign is_blank  = (byte_in == chtd_pkg::CHAR_SPACE) || (byte_in == chtd_pkg::CHAR_TAB);
   assign line_end  = (byte_in == chtd_pkg::CHAR_LF) && last_was_cr_ff;
   assign size_full = (size_accum_ff[SIZE_BITS-1 -: 4] != 4'd0);

   always_comb begin
      phase_in       = phase_ff;
      size_accum_in  = size_accum_ff;
      bytes_left_in  = bytes_left_ff;
      got_digit_in   = got_digit_ff;
      last_was_cr_in = last_was_cr_ff;
      skip_left_in   = skip_left_ff;
      result.data_byte  = 8'd0;
      result.is_payload = 1'b0;

      unique case (phase_ff)
         PH_LEAD, PH_DIGITS, PH_EXT: begin
            if (phase_ff != PH_EXT && is_hex) begin
               if (size_full) begin
                  phase_in = PH_ERROR;
               end else begin
                  size_accum_in = {size_accum_ff[SIZE_BITS-5:0], hex_val};
                  got_digit_in  = 1'b1;
                  phase_in      = PH_DIGITS;
               end
            end else if (phase_ff == PH_LEAD && is_blank) begin
               phase_in = PH_LEAD;
            end else if (line_end) begin
               last_was_cr_in = 1'b0;
               if (!got_digit_ff) begin
                  phase_in = PH_ERROR;
               end else if (size_accum_ff == '0) begin
                  phase_in = PH_DONE;
               end else begin
                  bytes_left_in = size_accum_ff;
                  phase_in      = PH_DATA;
               end
            end else begin
               last_was_cr_in = (byte_in == chtd_pkg::CHAR_CR);
               phase_in       = PH_EXT;
            end
         end
         PH_DATA: begin
            result.data_byte  = byte_in;
            result.is_payload = 1'b1;
            bytes_left_in     = bytes_left_ff - 1'b1;
            if (bytes_left_ff == SIZE_BITS'(1)) begin
               phase_in     = PH_TRAIL;
               skip_left_in = chtd_pkg::TRAIL_LEN;
            end
         end
         PH_TRAIL: begin
            skip_left_in = skip_left_ff - 2'd1;
            if (skip_left_ff == 2'd1) begin
               phase_in       = PH_LEAD;
               size_accum_in  = '0;
               got_digit_in   = 1'b0;
               last_was_cr_in = 1'b0;
            end
         end
         PH_DONE: begin
            phase_in = PH_DONE;
         end
         default: begin
            phase_in = PH_ERROR;
         end
      endcase

      result.finished  = (phase_in == PH_DONE);
      result.malformed = (phase_in == PH_ERROR);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_LEAD;
         size_accum_ff  <= '0;
         bytes_left_ff  <= '0;
         got_digit_ff   <= 1'b0;
         last_was_cr_ff <= 1'b0;
         skip_left_ff   <= 2'd0;
      end else if (step_en) begin
         phase_ff       <= phase_in;
         size_accum_ff  <= size_accum_in;
         bytes_left_ff  <= bytes_left_in;
         got_digit_ff   <= got_digit_in;
         last_was_cr_ff <= last_was_cr_in;
         skip_left_ff   <= skip_left_in;
      end
   end

endmodule

// ===== rtl/chunked_transfer_decoder.sv =====
`timescale 1ns / 1ps
// Chunked transfer decoder: one byte of a chunked message body per item.
// req channel: req_valid / req_stall carry req_in_byte.
// rsp channel: rsp_valid / rsp_stall carry one result item per input item:
//   rsp_data_byte (0 unless rsp_is_payload), rsp_is_payload, and the
//   sticky flags rsp_finished and rsp_malformed.
// An accepted item passes the input register, then the framing step into the
//   result register, where rsp_valid rises.
// Throughput: one item per cycle while rsp_stall is low; the framing step is a
//   single shift-add or decrement on the frame state.
// A stalled result holds in the result register while one more item may
//   wait in the input register; req_stall rises only when both are full and
//   rsp_stall is high.
// Reset (synchronous) empties both registers and returns the frame state to
//   the start of a size line with all counts and flags clear.

module chunked_transfer_decoder #(
   parameter int SIZE_BITS = chtd_pkg::SIZE_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_is_payload,
   output logic       rsp_finished,
   output logic       rsp_malformed
);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   chtd_pkg::result_type result_ff;
   chtd_pkg::result_type step_result;
   logic                 out_load;
   logic                 in_load;
   logic                 step_en;

   assign out_load     = !rsp_valid_ff || !rsp_stall;
   assign step_en      = in_valid_ff && out_load;
   assign in_load      = !in_valid_ff || out_load;
   assign req_stall    = !in_load;
   assign in_valid_in  = in_load ? req_valid : in_valid_ff;
   assign rsp_valid_in = out_load ? in_valid_ff : rsp_valid_ff;

   chtd_core #(
      .SIZE_BITS(SIZE_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .byte_in (in_byte_ff),
      .result  (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (in_load && req_valid) begin
         in_byte_ff <= req_in_byte;
      end
      if (step_en) begin
         result_ff <= step_result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data_byte  = result_ff.data_byte;
   assign rsp_is_payload = result_ff.is_payload;
   assign rsp_finished   = result_ff.finished;
   assign rsp_malformed  = result_ff.malformed;

endmodule

// ===== rtl/chtd_checker.sv =====
`timescale 1ns / 1ps

module chtd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_data_byte,
   input logic       rsp_is_payload,
   input logic       rsp_finished,
   input logic       rsp_malformed
);

   logic seen_done_ff, seen_done_in;
   logic seen_err_ff, seen_err_in;
   logic rsp_take;

   assign rsp_take     = rsp_valid && !rsp_stall;
   assign seen_done_in = seen_done_ff || (rsp_take && rsp_finished);
   assign seen_err_in  = seen_err_ff || (rsp_take && rsp_malformed);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_done_ff <= 1'b0;
         seen_err_ff  <= 1'b0;
      end else begin
         seen_done_ff <= seen_done_in;
         seen_err_ff  <= seen_err_in;
      end
   end

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data_byte)
         && $stable(rsp_is_payload) && $stable(rsp_finished) && $stable(rsp_malformed))
      else $error("rsp item changed while stalled");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_finished && rsp_malformed)
         && !(rsp_is_payload && (rsp_finished || rsp_malformed)))
      else $error("payload, finished and malformed overlap");

   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_done_ff |-> rsp_finished && !rsp_is_payload)
      else $error("finished dropped after terminating chunk");

   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_err_ff |-> rsp_malformed && !rsp_is_payload)
      else $error("malformed dropped after error");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind chunked_transfer_decoder chtd_checker u_chtd_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_data_byte  (rsp_data_byte),
   .rsp_is_payload (rsp_is_payload),
   .rsp_finished   (rsp_finished),
   .rsp_malformed  (rsp_malformed)
);
